// ----- sv/assert_macros.svh -----
// Assertion macros shared by the integral image stream modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge outside reset.
`define IIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define IIS_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- sv/iis_pkg.sv -----
// Package with shared constants and types of the integral image stream unit.
package iis_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = 28;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOVEA_ROWS   = 2'd2;

    localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 11'd256;
    localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 11'd256;
    localparam logic [CFG_W-1:0] RESET_FOVEA_ROWS   = 11'd0;

    typedef struct packed {
        logic first_col;
        logic top_row;
        logic fovea;
        logic frame_last;
    } pos_flags_t;

endpackage

// ----- sv/iis_pos.sv -----
// Column and row counters that place each accepted pixel in the frame.
module iis_pos
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [CFG_W-1:0]              image_width,
    input  logic [CFG_W-1:0]              image_height,
    input  logic [CFG_W-1:0]              fovea_rows,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output pos_flags_t                    flags
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int EH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [EW-1:0] col_inc;
    logic [EH-1:0] row_inc;
    logic          row_end;
    logic          frame_end;

    // A width or height of zero acts as one, and both are capped by MAX_WIDTH and MAX_HEIGHT.
    assign col_inc   = EW'(col_reg) + EW'(1);
    assign row_inc   = EH'(row_reg) + EH'(1);
    assign row_end   = (col_inc >= EW'(image_width)) || (col_reg == CW'(MAX_WIDTH - 1));
    assign frame_end = row_end &&
                       ((row_inc >= EH'(image_height)) || (row_reg == RW'(MAX_HEIGHT - 1)));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col              = col_reg;
    assign flags.first_col  = (col_reg == '0);
    assign flags.top_row    = (row_reg == '0);
    assign flags.fovea      = (EH'(row_reg) < EH'(fovea_rows));
    assign flags.frame_last = frame_end;

    `include "assert_macros.svh"

    `IIS_ASSERT(a_frame_wraps, accept && frame_end |=> col_reg == '0 && row_reg == '0, "counters did not restart after the last pixel of a frame")

endmodule

// ----- sv/iis_line_buf.sv -----
// Line buffer that holds the integral values of the previous row.
module iis_line_buf
    import iis_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = SUM_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/iis_sum.sv -----
// Summing stage: running row sum plus the value above, and the result register.
module iis_sum
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          accept,
    input  logic [PIXEL_W-1:0]            pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col_in,
    input  pos_flags_t                    flags_in,
    input  logic [SUM_W-1:0]              buf_q,
    output logic                          wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    output logic [SUM_W-1:0]              wr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SUM_W-1:0]              area_sum,
    output logic                          frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RUN_W = $clog2(MAX_WIDTH * 255 + 1);

    logic               s1_valid_reg;
    logic [CW-1:0]      s1_col_reg;
    pos_flags_t         s1_flags_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               fwd_reg;
    logic [SUM_W-1:0]   last_wr_reg;
    logic [RUN_W-1:0]   run_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_last_reg;

    logic               s1_fire;
    logic [SUM_W-1:0]   above;
    logic [RUN_W-1:0]   run_base;
    logic [RUN_W-1:0]   run_sum;
    logic [SUM_W-1:0]   result;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;

    // When the entry being read is written by the request just ahead, take the
    // written value instead of the stale buffer output.
    assign above    = s1_flags_reg.top_row ? '0 : (fwd_reg ? last_wr_reg : buf_q);
    assign run_base = s1_flags_reg.first_col ? '0 : run_reg;
    assign run_sum  = run_base + RUN_W'(s1_pixel_reg);
    assign result   = s1_flags_reg.fovea ? '0 : above + SUM_W'(run_sum);

    assign wr_en   = s1_fire;
    assign wr_addr = s1_col_reg;
    assign wr_data = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_fire && (s1_col_reg == col_in);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end

            if (s1_fire)
            begin
                run_reg       <= s1_flags_reg.fovea ? '0 : run_sum;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col_in;
            s1_flags_reg <= flags_in;
            s1_pixel_reg <= pixel;
        end
        if (s1_fire)
        begin
            last_wr_reg  <= result;
            out_sum_reg  <= result;
            out_last_reg <= s1_flags_reg.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign area_sum   = out_sum_reg;
    assign frame_last = out_last_reg;

    `include "assert_macros.svh"

    `IIS_ASSERT(a_stall_cause, !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready, "input stalled without a full pipeline")
    `IIS_ASSERT(a_fovea_zero, s1_fire && s1_flags_reg.fovea |=> out_sum_reg == '0, "fovea row gave a nonzero sum")
    `IIS_NEVER(a_fwd_orphan, fwd_reg && !s1_valid_reg, "forward flag set with an empty stage")

endmodule

// ----- sv/integral_image_stream_unit.sv -----
// Pipeline: an accepted request is registered in the input stage, then in the result
// register; while the output is stalled it waits in the input stage.
// Throughput: one request per cycle while the output is ready; the line buffer read is
// registered alongside the input stage, and one add stage feeds the result register.
// Reset: asynchronous and active low; it clears the counters and the valid flags and presets
// the configuration registers. The line buffer is not cleared and needs no sweep.
module integral_image_stream_unit
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIXEL_W-1:0]    s_axis_tdata,   // [7:0] pixel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [27:0] area_sum, [31:28] zero
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CFG_W-1:0] fovea_rows_reg;

    logic             accept;
    logic [CW-1:0]    col;
    pos_flags_t       flags;
    logic [SUM_W-1:0] buf_q;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [SUM_W-1:0] wr_data;
    logic [SUM_W-1:0] area_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RESET_IMAGE_WIDTH;
            image_height_reg <= RESET_IMAGE_HEIGHT;
            fovea_rows_reg   <= RESET_FOVEA_ROWS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_FOVEA_ROWS:   fovea_rows_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    iis_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .fovea_rows   (fovea_rows_reg),
        .col          (col),
        .flags        (flags)
    );

    iis_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SUM_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (buf_q)
    );

    iis_sum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_sum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .accept     (accept),
        .pixel      (s_axis_tdata),
        .col_in     (col),
        .flags_in   (flags),
        .buf_q      (buf_q),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .area_sum   (area_sum),
        .frame_last (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - SUM_W){1'b0}}, area_sum};

endmodule
